// File: sv/vfab_pkg.sv
`timescale 1ns / 1ps

package vfab_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int FACE_SLOTS   = 64;

  localparam int VERTEX_W = 13;
  localparam int SLOT_IN_W = 6;
  localparam int FACE_W   = 16;
  localparam int FCOUNT_W = 7;
  localparam int STATUS_W = 2;
  localparam int FUNC_W   = 2;

  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int SLOT_W  = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
  localparam int COUNT_W = $clog2(FACE_SLOTS + 1);
  localparam int LIM_W   = ($clog2(MAX_VERTICES + 1) > VERTEX_W) ?
                           $clog2(MAX_VERTICES + 1) : VERTEX_W;
  localparam int SX_W    = (COUNT_W > SLOT_IN_W) ? COUNT_W : SLOT_IN_W;
  localparam int FL_AW   = VIDX_W + SLOT_W;
  localparam int FL_DEPTH = MAX_VERTICES * (2 ** SLOT_W);

  localparam logic [FACE_W-1:0]   FACE_LIMIT = 16'hFFFF;
  localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 13'd4096;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUST = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [VERTEX_W-1:0]  vertex_a;
    logic [VERTEX_W-1:0]  vertex_b;
    logic [VERTEX_W-1:0]  vertex_c;
    logic [SLOT_IN_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VERTEX_W-1:0] vertex_number;
    logic [FCOUNT_W-1:0] face_count;
    logic [FACE_W-1:0]   face_number;
    logic                overflowed;
  } out_item_t;

  typedef struct packed {
    logic               ovf;
    logic [COUNT_W-1:0] cnt;
  } cnt_word_t;

  function automatic logic [VIDX_W-1:0] vertex_index(input logic [VERTEX_W-1:0] v);
    logic [LIM_W-1:0] t;
    t = LIM_W'(v) - LIM_W'(1);
    return t[VIDX_W-1:0];
  endfunction

endpackage

// File: sv/vfab_if.sv
`timescale 1ns / 1ps

interface vfab_in_if;
  import vfab_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfab_out_if;
  import vfab_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/vfab_ram.sv
`timescale 1ns / 1ps

module vfab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: sv/vfab_range_check.sv
`timescale 1ns / 1ps

module vfab_range_check (
  input  logic [vfab_pkg::VERTEX_W-1:0] vertex_i,
  input  logic [vfab_pkg::VERTEX_W-1:0] vertex_count_i,
  output logic                          ok_o
);
  import vfab_pkg::*;

  logic [LIM_W-1:0] v_x;
  logic [LIM_W-1:0] cnt_x;

  assign v_x   = LIM_W'(vertex_i);
  assign cnt_x = LIM_W'(vertex_count_i);

  // valid numbers run from 1 to min(vertex_count, MAX_VERTICES)
  assign ok_o = (v_x != '0) && (v_x <= cnt_x) && (v_x <= LIM_W'(MAX_VERTICES));

endmodule

// File: sv/vertex_face_adjacency_builder_core.sv
`timescale 1ns / 1ps

// vertex-to-face incidence table builder
// in_i carries one transaction per command: clear, add triangle or read one list slot.
// out_o returns exactly one result transaction per command, in order.
// cfg_we_i / cfg_wdata_i write vertex_count; write only while the block is idle.
// in_i.ready is high only while the sequencer is idle; one command is in work at a time.
// a single range comparator checks the corners one per cycle, and one port on the
// count memory does the three count updates, each a read state, then a write state.
// add: three checks, three updates and the result come before the next ready.
// an add with a corner out of range ends after its failing check plus the result,
// an add with face numbers exhausted after its three checks plus the result.
// read: check, count read, list read, result; an unfilled slot skips the list read,
// a vertex out of range goes from its check to the result; func 3 goes to the result.
// clear: one count word zeroed per cycle over all MAX_VERTICES words, then the result.
// after reset the same sweep runs with ready low and gives no result.
// results sit in an output register: the next command is accepted while one waits,
// and a stalled receiver holds the sequencer only when a second result is ready.
module vertex_face_adjacency_builder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vfab_pkg::VERTEX_W-1:0] cfg_wdata_i,
  vfab_in_if.sink                       in_i,
  vfab_out_if.source                    out_o
);
  import vfab_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_CHECK,
    S_ADD_RD,
    S_ADD_WR,
    S_RD_CNT,
    S_RD_FACE,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  in_item_t cmd_q, cmd_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [VERTEX_W-1:0] vcount_q, vcount_d;
  logic [FACE_W-1:0] next_face_q, next_face_d;
  logic [FACE_W-1:0] face_q, face_d;
  logic [1:0] corner_q, corner_d;
  logic full_q, full_d;
  logic emit_q, emit_d;
  logic [VIDX_W-1:0] clr_idx_q, clr_idx_d;

  logic [VERTEX_W-1:0] vsel;
  logic vsel_ok;
  logic [VIDX_W-1:0] vsel_idx;

  logic cram_we;
  logic [VIDX_W-1:0] cram_addr;
  cnt_word_t cram_wdata;
  logic [$bits(cnt_word_t)-1:0] cram_rdata;
  cnt_word_t cnt_rd;

  logic fram_we;
  logic [FL_AW-1:0] fram_addr;
  logic [FACE_W-1:0] fram_rdata;

  logic n_full;
  logic [SX_W-1:0] slot_x;
  logic slot_hit;

  always_comb begin
    case (corner_q)
      2'd0:    vsel = cmd_q.vertex_a;
      2'd1:    vsel = cmd_q.vertex_b;
      default: vsel = cmd_q.vertex_c;
    endcase
  end

  vfab_range_check u_range_check (
    .vertex_i       (vsel),
    .vertex_count_i (vcount_q),
    .ok_o           (vsel_ok)
  );

  assign vsel_idx = vertex_index(vsel);
  assign cnt_rd   = cnt_word_t'(cram_rdata);
  assign n_full   = cnt_rd.cnt >= COUNT_W'(FACE_SLOTS);
  assign slot_x   = SX_W'(cmd_q.slot);
  assign slot_hit = (slot_x < SX_W'(cnt_rd.cnt)) && (slot_x < SX_W'(FACE_SLOTS));

  assign fram_addr = (state_q == S_ADD_WR) ? {vsel_idx, cnt_rd.cnt[SLOT_W-1:0]}
                                           : {vsel_idx, slot_x[SLOT_W-1:0]};

  vfab_ram #(
    .WIDTH ($bits(cnt_word_t)),
    .DEPTH (MAX_VERTICES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .addr_i  (cram_addr),
    .wdata_i (cram_wdata),
    .rdata_o (cram_rdata)
  );

  vfab_ram #(
    .WIDTH (FACE_W),
    .DEPTH (FL_DEPTH)
  ) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (fram_we),
    .addr_i  (fram_addr),
    .wdata_i (face_q),
    .rdata_o (fram_rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    vcount_d    = cfg_we_i ? cfg_wdata_i : vcount_q;
    next_face_d = next_face_q;
    face_d      = face_q;
    corner_d    = corner_q;
    full_d      = full_q;
    emit_d      = emit_q;
    clr_idx_d   = clr_idx_q;
    cram_we     = 1'b0;
    cram_addr   = vsel_idx;
    cram_wdata  = '0;
    fram_we     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d    = in_i.data;
          res_d    = '0;
          corner_d = 2'd0;
          full_d   = 1'b0;
          case (in_i.data.func) inside
            FUNC_CLEAR: begin
              state_d     = S_CLEAR;
              clr_idx_d   = '0;
              emit_d      = 1'b1;
              next_face_d = '0;
            end
            FUNC_ADD, FUNC_READ: state_d = S_CHECK;
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_CLEAR: begin
        cram_addr = clr_idx_q;
        cram_we   = 1'b1;
        if (clr_idx_q == VIDX_W'(MAX_VERTICES - 1)) begin
          state_d = emit_q ? S_RESULT : S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + VIDX_W'(1);
        end
      end
      S_CHECK: begin
        if (!vsel_ok) begin
          res_d.status = ST_RANGE;
          state_d      = S_RESULT;
        end else if (cmd_q.func == FUNC_READ) begin
          state_d = S_RD_CNT;
        end else if (corner_q != 2'd2) begin
          corner_d = corner_q + 2'd1;
        end else if (next_face_q >= FACE_LIMIT) begin
          res_d.status = ST_EXHAUST;
          state_d      = S_RESULT;
        end else begin
          next_face_d = next_face_q + FACE_W'(1);
          face_d      = next_face_q + FACE_W'(1);
          corner_d    = 2'd0;
          state_d     = S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        cram_we = 1'b1;
        if (n_full) begin
          cram_wdata.ovf = 1'b1;
          cram_wdata.cnt = cnt_rd.cnt;
          full_d         = 1'b1;
        end else begin
          cram_wdata.ovf = cnt_rd.ovf;
          cram_wdata.cnt = cnt_rd.cnt + COUNT_W'(1);
          fram_we        = 1'b1;
        end
        if (corner_q == 2'd2) begin
          res_d.status      = (full_q || n_full) ? ST_FULL : ST_OK;
          res_d.face_number = face_q;
          state_d           = S_RESULT;
        end else begin
          corner_d = corner_q + 2'd1;
          state_d  = S_ADD_RD;
        end
      end
      S_RD_CNT: begin
        res_d.vertex_number = cmd_q.vertex_a;
        res_d.face_count    = FCOUNT_W'(cnt_rd.cnt);
        res_d.overflowed    = cnt_rd.ovf;
        state_d             = slot_hit ? S_RD_FACE : S_RESULT;
      end
      S_RD_FACE: begin
        res_d.face_number = fram_rdata;
        state_d           = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cmd_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      vcount_q    <= VCOUNT_RESET;
      next_face_q <= '0;
      face_q      <= '0;
      corner_q    <= 2'd0;
      full_q      <= 1'b0;
      emit_q      <= 1'b0;
      clr_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      vcount_q    <= vcount_d;
      next_face_q <= next_face_d;
      face_q      <= face_d;
      corner_q    <= corner_d;
      full_q      <= full_d;
      emit_q      <= emit_d;
      clr_idx_q   <= clr_idx_d;
    end
  end

endmodule
